FILE: sv/msbm_pkg.sv
// types and codes shared by the multi-signature byte matcher
// no dependencies; used by the interfaces, msbm_cmp and the top level
package msbm_pkg;

  localparam int unsigned LEN_W = 7;   // signature length field width
  localparam int unsigned POS_W = 32;  // scan position width

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_LEN     = 2'd1,
    KIND_SCAN    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [3:0]        sig_slot;
    logic [5:0]        byte_pos;
    logic [7:0]        value;
    logic [LEN_W-1:0]  sig_length;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        match_slot;
    logic [POS_W-1:0]  start_offset;
    logic [LEN_W-1:0]  match_length;
    logic              last_match;
  } out_item_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic sig_we;   // write a signature byte
    logic win_we;   // write a scan byte into the window
    logic rd_en;    // read one byte of each memory for comparison
    logic clear;    // start a new signature comparison
  } cmp_ctrl_t;

endpackage

FILE: sv/msbm_if.sv
// valid/ready channels for input items and match results
// depends on msbm_pkg
interface msbm_in_if;
  logic               valid;
  logic               ready;
  msbm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface msbm_out_if;
  logic                valid;
  logic                ready;
  msbm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/msbm_cmp.sv
// compare unit: signature memory, scan window memory and one byte comparator
// depends on msbm_pkg
module msbm_cmp #(
  parameter int unsigned SIG_AW    = 10,
  parameter int unsigned SIG_DEPTH = 1024,
  parameter int unsigned WIN_AW    = 6,
  parameter int unsigned WIN_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  msbm_pkg::cmp_ctrl_t ctrl_i,
  input  logic [SIG_AW-1:0]   sig_addr_i,
  input  logic [WIN_AW-1:0]   win_addr_i,
  input  logic [7:0]          wdata_i,
  output logic                mismatch_o
);

  logic [7:0] sig_mem [SIG_DEPTH];
  logic [7:0] win_mem [WIN_DEPTH];
  logic [7:0] sig_rd_q;
  logic [7:0] win_rd_q;
  logic       cmp_en_q;
  logic       mism_q;
  logic       diff;

  // single port each: written while idle, read while sweeping
  always_ff @(posedge clk_i) begin
    if (ctrl_i.sig_we) begin
      sig_mem[sig_addr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      sig_rd_q <= sig_mem[sig_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.win_we) begin
      win_mem[win_addr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      win_rd_q <= win_mem[win_addr_i];
    end
  end

  assign diff = (sig_rd_q != win_rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_en_q <= 1'b0;
      mism_q   <= 1'b0;
    end else begin
      cmp_en_q <= ctrl_i.rd_en;
      if (ctrl_i.clear) begin
        mism_q <= 1'b0;
      end else if (cmp_en_q) begin
        mism_q <= mism_q | diff;
      end
    end
  end

  // includes the byte pair read in the previous cycle
  assign mismatch_o = mism_q | (cmp_en_q & diff);

endmodule

FILE: sv/multi_signature_byte_matcher_top.sv
// multi-signature byte matcher: load, length and restart beats are taken in the idle state;
// a scan beat visits every slot in turn, skipping a disabled or too-early slot and sweeping
// a checked slot byte by byte, and takes longer while the result side stalls; one byte
// comparator does all the work
// reset clears position, window pointer, lengths and control; memories keep
// their contents, no clearing pass
module multi_signature_byte_matcher_top #(
  parameter int unsigned NUM_SIGS    = 16,
  parameter int unsigned MAX_SIG_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  msbm_in_if.sink    in_i,
  msbm_out_if.source out_o
);

  localparam int unsigned SIG_DEPTH = NUM_SIGS * MAX_SIG_LEN;
  localparam int unsigned SIG_AW    = (SIG_DEPTH > 1) ? $clog2(SIG_DEPTH) : 1;
  localparam int unsigned WIN_AW    = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
  localparam int unsigned SW        = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
  localparam int unsigned LEN_W     = msbm_pkg::LEN_W;
  localparam int unsigned POS_W     = msbm_pkg::POS_W;

  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a beat
    ST_SLOT,    // look at the length of the current slot
    ST_SWEEP,   // read one signature byte and one window byte a cycle
    ST_DRAIN,   // last compare lands
    ST_COMMIT,  // hand a found match to the pending register
    ST_FLUSH    // send the final match of this byte flagged as last
  } state_e;

  state_e                   state_q, state_d;
  logic [LEN_W-1:0]         len_q [NUM_SIGS];
  logic [LEN_W-1:0]         len_d [NUM_SIGS];
  logic [POS_W-1:0]         pos_q, pos_d;        // bytes since restart
  logic [POS_W-1:0]         offset_q, offset_d;  // offset of the byte being matched
  logic [WIN_AW-1:0]        wptr_q, wptr_d;      // next window write slot
  logic [WIN_AW-1:0]        newest_q, newest_d;  // window slot of the newest byte
  logic [SW-1:0]            slot_q, slot_d;
  logic [LEN_W-1:0]         cur_len_q, cur_len_d;
  logic [LEN_W-1:0]         idx_q, idx_d;        // byte index within the sweep
  logic [SIG_AW-1:0]        sig_ptr_q, sig_ptr_d;
  logic [WIN_AW-1:0]        win_ptr_q, win_ptr_d;
  logic                     hit_q, hit_d;
  logic                     pend_vld_q, pend_vld_d;
  msbm_pkg::out_item_t      pend_q, pend_d;
  logic                     out_vld_q, out_vld_d;
  msbm_pkg::out_item_t      out_q, out_d;

  msbm_pkg::cmp_ctrl_t      ctrl;
  logic [SIG_AW-1:0]        sig_addr;
  logic [WIN_AW-1:0]        win_addr;
  logic                     mismatch;

  logic                     in_acc;
  logic                     out_free;
  logic                     slot_ok;
  logic                     bpos_ok;
  logic [SIG_AW-1:0]        load_addr;
  logic [LEN_W-1:0          ] sat_len;
  logic [LEN_W-1:0]         slot_len;
  logic [LEN_W-1:0]         slot_lm1;
  logic [31:0]              win_start;
  logic                     last_slot;
  msbm_pkg::out_item_t      new_match;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign out_free   = ~out_vld_q | out_o.ready;

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // range checks for load and length beats
  assign slot_ok   = (32'(in_i.data.sig_slot) < 32'(NUM_SIGS));
  assign bpos_ok   = (32'(in_i.data.byte_pos) < 32'(MAX_SIG_LEN));
  assign load_addr = SIG_AW'(32'(in_i.data.sig_slot) * 32'(MAX_SIG_LEN)
                             + 32'(in_i.data.byte_pos));
  assign sat_len   = (32'(in_i.data.sig_length) > 32'(MAX_SIG_LEN)) ?
                     LEN_W'(MAX_SIG_LEN) : in_i.data.sig_length;

  // current slot and where its candidate begins in the circular window
  assign slot_len  = len_q[slot_q];
  assign slot_lm1  = slot_len - LEN_W'(1);
  assign win_start = (32'(newest_q) >= 32'(slot_lm1)) ?
                     32'(newest_q) - 32'(slot_lm1) :
                     32'(newest_q) + 32'(MAX_SIG_LEN) - 32'(slot_lm1);
  assign last_slot = (slot_q == SW'(NUM_SIGS - 1));

  assign new_match.match_slot   = 4'(slot_q);
  assign new_match.start_offset = offset_q - POS_W'(cur_len_q - LEN_W'(1));
  assign new_match.match_length = cur_len_q;
  assign new_match.last_match   = 1'b0;

  // compare unit control: memory ports serve writes when idle, reads when sweeping
  always_comb begin
    ctrl.sig_we = in_acc & (in_i.data.kind == msbm_pkg::KIND_LOAD) & slot_ok & bpos_ok;
    ctrl.win_we = in_acc & (in_i.data.kind == msbm_pkg::KIND_SCAN);
    ctrl.rd_en  = (state_q == ST_SWEEP);
    ctrl.clear  = (state_q == ST_SLOT);
  end

  assign sig_addr = (state_q == ST_IDLE) ? load_addr : sig_ptr_q;
  assign win_addr = (state_q == ST_IDLE) ? wptr_q : win_ptr_q;

  msbm_cmp #(
    .SIG_AW    (SIG_AW),
    .SIG_DEPTH (SIG_DEPTH),
    .WIN_AW    (WIN_AW),
    .WIN_DEPTH (MAX_SIG_LEN)
  ) u_cmp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .sig_addr_i (sig_addr),
    .win_addr_i (win_addr),
    .wdata_i    (in_i.data.value),
    .mismatch_o (mismatch)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    pos_d      = pos_q;
    offset_d   = offset_q;
    wptr_d     = wptr_q;
    newest_d   = newest_q;
    slot_d     = slot_q;
    cur_len_d  = cur_len_q;
    idx_d      = idx_q;
    sig_ptr_d  = sig_ptr_q;
    win_ptr_d  = win_ptr_q;
    hit_d      = hit_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q & ~out_o.ready;
    out_d      = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_i.data.kind)
            msbm_pkg::KIND_LOAD: begin
              // memory write is driven straight from the beat
            end
            msbm_pkg::KIND_LEN: begin
              if (slot_ok) begin
                len_d[SW'(in_i.data.sig_slot)] = sat_len;
              end
            end
            msbm_pkg::KIND_SCAN: begin
              offset_d = pos_q;
              if (pos_q != '1) begin
                pos_d = pos_q + POS_W'(1);
              end
              newest_d = wptr_q;
              wptr_d   = (wptr_q == WIN_AW'(MAX_SIG_LEN - 1)) ?
                         '0 : wptr_q + WIN_AW'(1);
              slot_d   = '0;
              state_d  = ST_SLOT;
            end
            msbm_pkg::KIND_RESTART: begin
              pos_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SLOT: begin
        // disabled slot, or not enough bytes since restart
        if ((slot_len == '0) || (offset_q < POS_W'(slot_lm1))) begin
          if (last_slot) begin
            state_d = ST_FLUSH;
          end else begin
            slot_d = slot_q + SW'(1);
          end
        end else begin
          cur_len_d = slot_len;
          idx_d     = '0;
          sig_ptr_d = SIG_AW'(32'(slot_q) * 32'(MAX_SIG_LEN));
          win_ptr_d = WIN_AW'(win_start);
          state_d   = ST_SWEEP;
        end
      end

      ST_SWEEP: begin
        sig_ptr_d = sig_ptr_q + SIG_AW'(1);
        win_ptr_d = (win_ptr_q == WIN_AW'(MAX_SIG_LEN - 1)) ?
                    '0 : win_ptr_q + WIN_AW'(1);
        idx_d     = idx_q + LEN_W'(1);
        if (idx_q == cur_len_q - LEN_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        hit_d   = ~mismatch;
        state_d = ST_COMMIT;
      end

      ST_COMMIT: begin
        // a previous match of this byte is known not to be the last one now
        if (hit_q && pend_vld_q && !out_free) begin
          state_d = ST_COMMIT;
        end else begin
          if (hit_q) begin
            if (pend_vld_q) begin
              out_vld_d = 1'b1;
              out_d     = pend_q;
            end
            pend_vld_d = 1'b1;
            pend_d     = new_match;
          end
          if (last_slot) begin
            state_d = ST_FLUSH;
          end else begin
            slot_d  = slot_q + SW'(1);
            state_d = ST_SLOT;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_vld_d           = 1'b1;
          out_d               = pend_q;
          out_d.last_match    = 1'b1;
          pend_vld_d          = 1'b0;
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state, slot lengths, working registers and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      for (int i = 0; i < int'(NUM_SIGS); i++) begin
        len_q[i] <= '0;
      end
      pos_q      <= '0;
      wptr_q     <= '0;
      newest_q   <= '0;
      slot_q     <= '0;
      idx_q      <= '0;
      hit_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      offset_q   <= '0;
      cur_len_q  <= '0;
      sig_ptr_q  <= '0;
      win_ptr_q  <= '0;
      pend_q     <= '0;
      out_q      <= '0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      pos_q      <= pos_d;
      wptr_q     <= wptr_d;
      newest_q   <= newest_d;
      slot_q     <= slot_d;
      idx_q      <= idx_d;
      hit_q      <= hit_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      offset_q   <= offset_d;
      cur_len_q  <= cur_len_d;
      sig_ptr_q  <= sig_ptr_d;
      win_ptr_q  <= win_ptr_d;
      pend_q     <= pend_d;
      out_q      <= out_d;
    end
  end

endmodule

FILE: test/tb_top.sv
// self-checking testbench for multi_signature_byte_matcher_top: directed table, then random beats
// depends on msbm_pkg, msbm_in_if and msbm_out_if; predicts every match and checks it in order
module tb_top;
  import msbm_pkg::*;

  localparam int unsigned NUM_SIGS        = 16;
  localparam int unsigned MAX_SIG_LEN     = 64;
  localparam int unsigned ITEMS_TOTAL     = 430;
  localparam int unsigned IDLE_PCT        = 9;
  localparam int unsigned HOLD_OFF_CYCLES = 3000;
  // time for the slowest scan beat to finish, plus some margin
  localparam int unsigned DRAIN_CYCLES    = 1200;
  localparam int unsigned WATCHDOG_LIMIT  = 20000;

  // how a directed row gets its expectation
  typedef enum {
    CHK_MODEL,  // from the predictor
    CHK_NONE,   // typed in: no match at all
    CHK_ONE     // typed in: exactly one match
  } chk_e;

  typedef struct {
    in_item_t  beat;
    chk_e      how;
    out_item_t want;
  } dir_row_t;

  // signature ff 00 in slot 0, ending at scan offset 2
  localparam out_item_t FF00_AT_1 = '{match_slot: 4'd0, start_offset: 32'd1,
                                      match_length: 7'd2, last_match: 1'b1};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  msbm_in_if  in_ch ();
  msbm_out_if out_ch ();

  multi_signature_byte_matcher_top #(
    .NUM_SIGS    (NUM_SIGS),
    .MAX_SIG_LEN (MAX_SIG_LEN)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state: our own copy of the signature table and scan history
  logic [7:0]       sig_mem     [NUM_SIGS][MAX_SIG_LEN];
  bit               sig_written [NUM_SIGS][MAX_SIG_LEN];
  logic [LEN_W-1:0] sig_len     [NUM_SIGS];
  logic [7:0]       recent_bytes [MAX_SIG_LEN];  // newest at index 0
  logic [POS_W-1:0] scan_pos;

  out_item_t pending_matches[$];  // matches still owed by the block, oldest first
  dir_row_t  dir_tab[$];
  int unsigned n_sent;
  int unsigned n_errors;
  bit          no_idle;       // both sides run flat out while set
  bit          hold_off_due;  // asks the result side for one long stall

  // applies one accepted beat to the predictor state and returns the matches it causes
  function automatic void find_matches(input in_item_t b, output out_item_t found[$]);
    int unsigned l;
    int unsigned n_hits;
    int unsigned seen;
    bit          hit [NUM_SIGS];
    case (b.kind)
      KIND_LOAD: begin
        sig_mem[b.sig_slot][b.byte_pos]     = b.value;
        sig_written[b.sig_slot][b.byte_pos] = 1'b1;
      end
      KIND_LEN: begin
        sig_len[b.sig_slot] = (b.sig_length > MAX_SIG_LEN) ? LEN_W'(MAX_SIG_LEN) : b.sig_length;
      end
      KIND_RESTART: begin
        // history stays, but the position guard keeps old bytes out of any match
        scan_pos = '0;
      end
      default: begin
        for (int k = MAX_SIG_LEN - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
        recent_bytes[0] = b.value;
        n_hits = 0;
        for (int unsigned s = 0; s < NUM_SIGS; s++) begin
          l = sig_len[s];
          hit[s] = (l != 0) && (scan_pos >= l - 1);
          for (int unsigned j = 0; j < l; j++) begin
            if (hit[s] && sig_mem[s][j] != recent_bytes[l - 1 - j]) hit[s] = 1'b0;
          end
          if (hit[s]) n_hits++;
        end
        // ascending slot order, last flag on the final one
        seen = 0;
        for (int unsigned s = 0; s < NUM_SIGS; s++) begin
          if (hit[s]) begin
            seen++;
            found.push_back('{match_slot: 4'(s),
                              start_offset: scan_pos - POS_W'(sig_len[s] - 1),
                              match_length: sig_len[s],
                              last_match: (seen == n_hits)});
          end
        end
        if (scan_pos != '1) scan_pos++;
      end
    endcase
  endfunction

  // fields a beat does not use are filled at random
  function automatic in_item_t beat_of(kind_e k, int unsigned slot, int unsigned pos,
                                       logic [7:0] val, int unsigned len);
    in_item_t b;
    b.kind       = k;
    b.sig_slot   = 4'($urandom_range(0, 15));
    b.byte_pos   = 6'($urandom_range(0, 63));
    b.value      = 8'($urandom_range(0, 255));
    b.sig_length = LEN_W'($urandom_range(0, 127));
    case (k)
      KIND_LOAD: begin
        b.sig_slot = 4'(slot);
        b.byte_pos = 6'(pos);
        b.value    = val;
      end
      KIND_LEN: begin
        b.sig_slot   = 4'(slot);
        b.sig_length = LEN_W'(len);
      end
      KIND_SCAN: b.value = val;
      default: ;
    endcase
    return b;
  endfunction

  function automatic in_item_t load_of(int unsigned slot, int unsigned pos, logic [7:0] val);
    return beat_of(KIND_LOAD, slot, pos, val, 0);
  endfunction

  function automatic in_item_t len_of(int unsigned slot, int unsigned len);
    return beat_of(KIND_LEN, slot, 0, 8'h00, len);
  endfunction

  function automatic in_item_t scan_of(logic [7:0] val);
    return beat_of(KIND_SCAN, 0, 0, val, 0);
  endfunction

  function automatic in_item_t restart_of();
    return beat_of(KIND_RESTART, 0, 0, 8'h00, 0);
  endfunction

  function automatic void add_row(in_item_t b, chk_e how = CHK_MODEL, out_item_t want = '0);
    dir_tab.push_back('{b, how, want});
  endfunction

  // small alphabet so that signatures turn up in the scan stream by chance too
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h3C;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly short signatures; full and saturated lengths stay rare as they slow every scan
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 13) return MAX_SIG_LEN;
    if (r < 16) return $urandom_range(MAX_SIG_LEN + 1, 127);
    return $urandom_range(1, 6);
  endfunction

  // offers one beat, waits for the handshake, then queues what it should cause
  task automatic send_beat(input in_item_t b, input chk_e how = CHK_MODEL,
                           input out_item_t want = '0);
    out_item_t found[$];
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    find_matches(b, found);
    case (how)
      CHK_MODEL: foreach (found[i]) pending_matches.push_back(found[i]);
      CHK_ONE:   pending_matches.push_back(want);
      default: ;
    endcase
    n_sent++;
  endtask

  // enabling a slot must never let the comparator read an unwritten byte
  task automatic program_slot(input int unsigned slot, input int unsigned len_field);
    int unsigned used;
    used = (len_field > MAX_SIG_LEN) ? MAX_SIG_LEN : len_field;
    for (int unsigned p = 0; p < used; p++) begin
      if (!sig_written[slot][p] || $urandom_range(0, 1) == 1)
        send_beat(load_of(slot, p, pick_byte()));
    end
    send_beat(len_of(slot, len_field));
  endtask

  // feeds an enabled signature into the scan, now and then with one byte spoilt
  task automatic scan_signature(input int unsigned slot);
    int unsigned n;
    int unsigned spoil;
    n     = sig_len[slot];
    spoil = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : n;
    for (int unsigned j = 0; j < n; j++)
      send_beat(scan_of((j == spoil) ? sig_mem[slot][j] ^ 8'h01 : sig_mem[slot][j]));
  endtask

  task automatic scan_burst();
    int unsigned n_fill;
    int unsigned s;
    n_fill = $urandom_range(0, 10);
    repeat (n_fill) send_beat(scan_of(pick_byte()));
    s = $urandom_range(0, NUM_SIGS - 1);
    if (sig_len[s] != 0 && $urandom_range(0, 3) != 0) scan_signature(s);
  endtask

  // same one-byte signature in every slot: one scan beat then owes a match per slot
  task automatic flood_slots();
    logic [7:0] v;
    v = pick_byte();
    for (int unsigned s = 0; s < NUM_SIGS; s++) begin
      send_beat(load_of(s, 0, v));
      send_beat(len_of(s, 1));
    end
    send_beat(scan_of(v));
  endtask

  // result side: random stalls, one long hold-off on request, counted here
  initial begin : result_ready_drive
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        @(posedge clk_i);
      end
    end
  end

  // every match beat is compared with the oldest owed match
  always @(posedge clk_i) begin : match_check
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready) begin
      got = out_ch.data;
      if (pending_matches.size() == 0) begin
        $error("unexpected match: slot %0d start %0d length %0d", got.match_slot,
               got.start_offset, got.match_length);
        n_errors++;
      end else begin
        want = pending_matches.pop_front();
        if (got.match_slot !== want.match_slot) begin
          $error("match_slot: expected %0d, got %0d", want.match_slot, got.match_slot);
          n_errors++;
        end
        if (got.start_offset !== want.start_offset) begin
          $error("start_offset: expected %0d, got %0d", want.start_offset, got.start_offset);
          n_errors++;
        end
        if (got.match_length !== want.match_length) begin
          $error("match_length: expected %0d, got %0d", want.match_length, got.match_length);
          n_errors++;
        end
        if (got.last_match !== want.last_match) begin
          $error("last_match: expected %0d, got %0d", want.last_match, got.last_match);
          n_errors++;
        end
      end
    end
  end

  // ends the run if neither channel moves a beat for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned r;
    bit          hold_done;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    hold_done = 1'b0;
    scan_pos  = '0;
    foreach (sig_len[s]) sig_len[s] = '0;
    foreach (recent_bytes[k]) recent_bytes[k] = 8'h00;
    foreach (sig_mem[s, p]) begin
      sig_mem[s][p]     = 8'h00;
      sig_written[s][p] = 1'b0;
    end

    // directed part
    add_row(scan_of(8'h00), CHK_NONE);              // every slot disabled after reset
    add_row(load_of(0, 0, 8'hFF));
    add_row(load_of(0, 1, 8'h00));
    add_row(len_of(0, 2));
    add_row(scan_of(8'hFF), CHK_NONE);              // history ends 00 ff, no match
    add_row(scan_of(8'h00), CHK_ONE, FF00_AT_1);
    add_row(scan_of(8'hFF), CHK_NONE);
    add_row(restart_of());
    add_row(scan_of(8'h00), CHK_NONE);              // ff 00 in history but ff is pre-restart
    add_row(scan_of(8'hFF), CHK_NONE);
    add_row(scan_of(8'h00), CHK_ONE, FF00_AT_1);    // same offsets once more after restart
    add_row(len_of(0, 0));                          // length zero disables the slot
    add_row(scan_of(8'hFF), CHK_NONE);
    add_row(scan_of(8'h00), CHK_NONE);
    add_row(load_of(3, 0, 8'hA5));
    add_row(load_of(15, 0, 8'hA5));
    add_row(len_of(3, 1));
    add_row(len_of(15, 1));
    add_row(len_of(0, 2));
    add_row(scan_of(8'hA5));                        // two slots on one beat
    add_row(load_of(15, 63, 8'h5A));                // last byte position
    add_row(scan_of(8'hFF), CHK_NONE);
    add_row(scan_of(8'h00));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].how, dir_tab[i].want);

    // random part opens with the widest beat and a saturated full-length signature
    flood_slots();
    program_slot(NUM_SIGS - 1, 127);
    scan_signature(NUM_SIGS - 1);
    program_slot(NUM_SIGS - 1, MAX_SIG_LEN);
    scan_signature(NUM_SIGS - 1);

    while (n_sent < ITEMS_TOTAL) begin
      // one stretch with no idling on either side
      no_idle = (n_sent >= 290 && n_sent < 360);
      // later on, a long result stall while beats keep coming
      if (!hold_done && n_sent >= 370) begin
        hold_off_due = 1'b1;
        hold_done    = 1'b1;
        flood_slots();
      end
      r = $urandom_range(0, 99);
      if (r < 30)
        program_slot($urandom_range(0, NUM_SIGS - 1), pick_len());
      else if (r < 82)
        scan_burst();
      else if (r < 88)
        send_beat(restart_of());
      else if (r < 99)
        send_beat(load_of($urandom_range(0, NUM_SIGS - 1), $urandom_range(0, MAX_SIG_LEN - 1),
                          8'($urandom_range(0, 255))));
      else
        flood_slots();
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;

    // drain what is still owed, then give a trailing scan time to misbehave
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
